@@ hw/rtl/ifse_pkg.sv @@
package ifse_pkg;

   // framing and escape bytes
   localparam logic [7:0] FLAG_BYTE   = 8'h7E;
   localparam logic [7:0] ESCAPE_BYTE = 8'h7D;
   localparam logic [7:0] ESC_OF_FLAG = 8'h5E;
   localparam logic [7:0] ESC_OF_ESC  = 8'h5D;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] REG_ADDRESS   = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CTRL_ZERO = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CTRL_ONE  = 8'd2;

   // configuration reset values
   localparam logic [7:0] ADDRESS_RESET   = 8'd3;
   localparam logic [7:0] CTRL_ZERO_RESET = 8'd0;
   localparam logic [7:0] CTRL_ONE_RESET  = 8'd64;

   // output symbols of one frame, in wire order
   localparam int unsigned SYM_W = 3;
   localparam logic [SYM_W-1:0] SYM_FLAG_OPEN  = 3'd0;
   localparam logic [SYM_W-1:0] SYM_ADDRESS    = 3'd1;
   localparam logic [SYM_W-1:0] SYM_CONTROL    = 3'd2;
   localparam logic [SYM_W-1:0] SYM_HEADER_CHK = 3'd3;
   localparam logic [SYM_W-1:0] SYM_DATA       = 3'd4;
   localparam logic [SYM_W-1:0] SYM_PAYLOAD_CHK = 3'd5;
   localparam logic [SYM_W-1:0] SYM_FLAG_CLOSE = 3'd6;

   // one classified payload byte, passed from front to back
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       open;
      logic [7:0] ctrl;
      logic [7:0] check;
   } job_type;

endpackage

@@ hw/rtl/ifse_front.sv @@
module ifse_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_data_byte,
   input  logic                req_last_byte,
   input  logic [7:0]          ctrl_zero,
   input  logic [7:0]          ctrl_one,
   input  logic                queue_full,
   output logic                push,
   output ifse_pkg::job_type   job
);

   logic       in_frame_ff, in_frame_in;
   logic       seq_ff, seq_in;
   logic [7:0] check_ff, check_in;
   logic [7:0] check_next;

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;

   // classify the transaction and fold it into the running check
   always_comb begin
      check_next = (in_frame_ff ? check_ff : 8'd0) ^ req_data_byte;
      job.data   = req_data_byte;
      job.last   = req_last_byte;
      job.open   = !in_frame_ff;
      job.ctrl   = seq_ff ? ctrl_one : ctrl_zero;
      job.check  = check_next;
   end

   // frame state update
   always_comb begin
      in_frame_in = in_frame_ff;
      seq_in      = seq_ff;
      check_in    = check_ff;
      if (push) begin
         if (req_last_byte) begin
            in_frame_in = 1'b0;
            seq_in      = !seq_ff;
            check_in    = 8'd0;
         end else begin
            in_frame_in = 1'b1;
            check_in    = check_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         seq_ff      <= 1'b0;
         check_ff    <= 8'd0;
      end else begin
         in_frame_ff <= in_frame_in;
         seq_ff      <= seq_in;
         check_ff    <= check_in;
      end
   end

endmodule

@@ hw/rtl/ifse_queue.sv @@
module ifse_queue #(
   parameter int unsigned Depth = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ifse_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output ifse_pkg::job_type head_job
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   ifse_pkg::job_type entry_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full       = (count_ff == FullCnt);
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ hw/rtl/ifse_back.sv @@
module ifse_back (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        address,
   input  logic              head_valid,
   input  ifse_pkg::job_type head_job,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_last_of_run,
   output logic              rsp_frame_end
);

   logic                       busy_ff, busy_in;
   logic [ifse_pkg::SYM_W-1:0] sym_ff, sym_in;
   logic                       esc_ff, esc_in;
   logic                       valid_ff, valid_in;
   logic [7:0]                 byte_ff, byte_in;
   logic                       last_ff, last_in;
   logic                       fend_ff, fend_in;

   logic                       load;
   logic [ifse_pkg::SYM_W-1:0] cur_sym;
   logic [ifse_pkg::SYM_W-1:0] end_sym;
   logic [7:0]                 sym_val;
   logic                       sym_raw;
   logic                       needs_esc;
   logic                       sym_done;
   logic                       item_done;

   assign load    = head_valid && (!valid_ff || rsp_ready);
   assign cur_sym = busy_ff ? sym_ff
                  : (head_job.open ? ifse_pkg::SYM_FLAG_OPEN : ifse_pkg::SYM_DATA);
   assign end_sym = head_job.last ? ifse_pkg::SYM_FLAG_CLOSE : ifse_pkg::SYM_DATA;

   // symbol value for the current step
   always_comb begin
      sym_raw = 1'b0;
      unique case (cur_sym)
         ifse_pkg::SYM_FLAG_OPEN: begin
            sym_val = ifse_pkg::FLAG_BYTE;
            sym_raw = 1'b1;
         end
         ifse_pkg::SYM_ADDRESS:     sym_val = address;
         ifse_pkg::SYM_CONTROL:     sym_val = head_job.ctrl;
         ifse_pkg::SYM_HEADER_CHK:  sym_val = address ^ head_job.ctrl;
         ifse_pkg::SYM_DATA:        sym_val = head_job.data;
         ifse_pkg::SYM_PAYLOAD_CHK: sym_val = head_job.check;
         default: begin
            sym_val = ifse_pkg::FLAG_BYTE;
            sym_raw = 1'b1;
         end
      endcase
   end

   // stuffing of the symbol into one or two wire bytes
   always_comb begin
      needs_esc = !sym_raw && ((sym_val == ifse_pkg::FLAG_BYTE)
                            || (sym_val == ifse_pkg::ESCAPE_BYTE));
      sym_done  = !needs_esc || esc_ff;
      item_done = sym_done && (cur_sym == end_sym);
      if (esc_ff) begin
         byte_in = (sym_val == ifse_pkg::FLAG_BYTE) ? ifse_pkg::ESC_OF_FLAG
                                                     : ifse_pkg::ESC_OF_ESC;
      end else if (needs_esc) begin
         byte_in = ifse_pkg::ESCAPE_BYTE;
      end else begin
         byte_in = sym_val;
      end
      last_in = item_done;
      fend_in = item_done && (cur_sym == ifse_pkg::SYM_FLAG_CLOSE);
   end

   assign pop = load && item_done;

   // step sequencer
   always_comb begin
      busy_in  = busy_ff;
      sym_in   = sym_ff;
      esc_in   = esc_ff;
      valid_in = valid_ff && !rsp_ready;
      if (load) begin
         valid_in = 1'b1;
         if (!sym_done) begin
            esc_in  = 1'b1;
            busy_in = 1'b1;
            sym_in  = cur_sym;
         end else if (item_done) begin
            esc_in  = 1'b0;
            busy_in = 1'b0;
         end else begin
            esc_in  = 1'b0;
            busy_in = 1'b1;
            sym_in  = cur_sym + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         sym_ff   <= ifse_pkg::SYM_FLAG_OPEN;
         esc_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         sym_ff   <= sym_in;
         esc_ff   <= esc_in;
         valid_ff <= valid_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= byte_in;
         last_ff <= last_in;
         fend_ff <= fend_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_last_of_run = last_ff;
   assign rsp_frame_end   = fend_ff;

   // closing flag always ends the run of its transaction
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff && fend_ff) |-> (last_ff && byte_ff == ifse_pkg::FLAG_BYTE))
      else $error("frame end without closing flag");

   // second half of an escape is always an escaped code
   assert property (@(posedge clock) disable iff (reset)
      (load && esc_ff) |=> (byte_ff == ifse_pkg::ESC_OF_FLAG
                            || byte_ff == ifse_pkg::ESC_OF_ESC))
      else $error("bad escape continuation");

   // an escape never ends a transaction's run
   assert property (@(posedge clock) disable iff (reset)
      (load && needs_esc && !esc_ff) |-> !pop)
      else $error("pop in the middle of an escape");

   // escape pending implies a symbol in progress
   assert property (@(posedge clock) disable iff (reset)
      esc_ff |-> busy_ff)
      else $error("escape pending while idle");

endmodule

@@ hw/rtl/info_frame_stuffing_encoder_top.sv @@
// Information frame encoder with byte stuffing.
// Request channel (req_): one payload byte per transaction, req_last_byte
// marks the final byte of a frame. Response channel (rsp_): one wire byte
// per transaction; rsp_last_of_run marks the final byte caused by a request,
// rsp_frame_end marks the closing flag. The first byte of a frame is
// preceded by flag, address, control and header check; the last byte is
// followed by the payload check and the closing flag. Everything between
// the flags is escaped (0x7E -> 0x7D 0x5E, 0x7D -> 0x7D 0x5D).
// Configuration (csr_): index 0 address, 1 control for sequence zero,
// 2 control for sequence one; other indexes are ignored. csr_ready is
// always high; write only while no request is in flight.
// The first byte of a request passes through the queue and the output
// register before it is on rsp_. The back end emits one wire byte per cycle
// while the queue holds a request and rsp_ready is high; a plain middle
// byte gives 1 to 2 wire bytes and a one-byte frame up to 12.
// A queue of QueueDepth requests sits between front and back, so requests
// are taken while responses wait; when rsp_ready is low the output register
// holds and req_ready drops once the queue fills.
// Reset clears the queue, closes any open frame, zeroes the sequence bit
// and the running check, and restores the register defaults.
module info_frame_stuffing_encoder_top #(
   parameter int unsigned QueueDepth = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_data_byte,
   input  logic                              req_last_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_out_byte,
   output logic                              rsp_last_of_run,
   output logic                              rsp_frame_end,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ifse_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [7:0]                        csr_data
);

   logic [7:0] address_ff, address_in;
   logic [7:0] ctrl_zero_ff, ctrl_zero_in;
   logic [7:0] ctrl_one_ff, ctrl_one_in;

   logic              queue_full;
   logic              push;
   logic              pop;
   logic              head_valid;
   ifse_pkg::job_type push_job;
   ifse_pkg::job_type head_job;

   assign csr_ready = 1'b1;

   // register write decode
   always_comb begin
      address_in   = address_ff;
      ctrl_zero_in = ctrl_zero_ff;
      ctrl_one_in  = ctrl_one_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ifse_pkg::REG_ADDRESS:   address_in   = csr_data;
            ifse_pkg::REG_CTRL_ZERO: ctrl_zero_in = csr_data;
            ifse_pkg::REG_CTRL_ONE:  ctrl_one_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         address_ff   <= ifse_pkg::ADDRESS_RESET;
         ctrl_zero_ff <= ifse_pkg::CTRL_ZERO_RESET;
         ctrl_one_ff  <= ifse_pkg::CTRL_ONE_RESET;
      end else begin
         address_ff   <= address_in;
         ctrl_zero_ff <= ctrl_zero_in;
         ctrl_one_ff  <= ctrl_one_in;
      end
   end

   // request classification
   ifse_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .ctrl_zero     (ctrl_zero_ff),
      .ctrl_one      (ctrl_one_ff),
      .queue_full    (queue_full),
      .push          (push),
      .job           (push_job)
   );

   // decoupling queue
   ifse_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // byte serializer and stuffing
   ifse_back u_back (
      .clock           (clock),
      .reset           (reset),
      .address         (address_ff),
      .head_valid      (head_valid),
      .head_job        (head_job),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_frame_end   (rsp_frame_end)
   );

endmodule
